>>> src/rft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rft_pkg
// Shared types, constants and the sine table function for the rigid frame
// transform block.
// ----------------------------------------------------------------------------
package rft_pkg;

	localparam int DEF_SINE_TABLE_DEPTH = 1024;
	localparam int DEF_SINE_WIDTH       = 18;

	localparam int FULL_TURN    = 46080;
	localparam int HALF_TURN    = 23040;
	localparam int QUARTER_TURN = 11520;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// index = floor(floor(n / 256) / 45), the second step by reciprocal
	localparam int RECIP_SH = 26;
	localparam int RECIP    = 1491309;
	localparam int RECIP_W  = 21;

	localparam int CFG_IDX_W = 2;
	localparam int ORIGIN_X_RESET = 35253125;
	localparam int ORIGIN_Y_RESET = -27300987;

	localparam int COEF_W = 32;   // multiplier coefficient operand
	localparam int DATA_W = 34;   // multiplier data operand
	localparam int ACC_W  = 66;
	localparam int RES_W  = 52;   // rounded term
	localparam int SUM_W  = 54;

	typedef enum logic [1:0] {
		KIND_EGO  = 2'd0,
		KIND_OBST = 2'd1,
		KIND_VEH  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1
	} reg_idx_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_ANGLE, ST_INDEX, ST_SIN, ST_COS,
		ST_G01, ST_G02, ST_G03, ST_G04, ST_G05,
		ST_G06, ST_G07, ST_G08, ST_G09, ST_G10,
		ST_DIFF,
		ST_L01, ST_L02, ST_L03, ST_L04, ST_L05, ST_L06,
		ST_L07, ST_L08, ST_L09, ST_L10, ST_L11, ST_L12,
		ST_DONE
	} rft_state_t;

	typedef enum logic [3:0] {
		A_PX, A_PY, A_VX, A_VY, A_P1, A_P2, A_DX, A_DY,
		A_GVX, A_GVY, A_LYU, A_U
	} a_sel_t;

	typedef enum logic [2:0] {
		B_S, B_C, B_NS, B_NC, B_W
	} b_sel_t;

	typedef enum logic [3:0] {
		D_NONE, D_P1, D_P2, D_T, D_GVX, D_GVY, D_LX, D_LY, D_LVX, D_U, D_LVY
	} dst_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic   first;
		logic   shift16;
		dst_t   dst;
	} mac_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [31:0] res;
		if (x > SUM_W'(64'sd2147483647))
			res = 32'sh7fffffff;
		else if (x < -SUM_W'(64'sd2147483648))
			res = 32'sh80000000;
		else
			res = x[31:0];
		return res;
	endfunction

	// wrap into -23040..23039; input stays within one turn of the range
	function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] a);
		logic signed [18:0] t;
		t = 19'(a) + 19'(HALF_TURN);
		if (t < 0)
			t = t + 19'(FULL_TURN);
		else if (t >= 19'(FULL_TURN))
			t = t - 19'(FULL_TURN);
		t = t - 19'(HALF_TURN);
		return t[15:0];
	endfunction

	// sine table entry by integer Taylor series, Q30 rounded to Q(Frac)
	function automatic logic [31:0] sine_entry(input int unsigned Idx,
			input int unsigned Depth, input int unsigned Frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          v;
		longint          lim;
		int unsigned     n;
		x    = (HALF_PI_Q30 * 64'(Idx) + 64'(Depth / 2)) / 64'(Depth);
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (n = 1; n <= 14; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) != 0)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (Frac >= 30)
			v = sum;
		else
			v = (sum + (64'sd1 <<< (29 - Frac))) >>> (30 - Frac);
		lim = 64'sd1 <<< Frac;
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

>>> src/rft_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rft interfaces
// Item, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rft_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [15:0] heading;
	logic signed [23:0] yaw_rate;

	modport source(output valid, kind, pos_x, pos_y, vel_x, vel_y, heading, yaw_rate,
		input ready);
	modport sink(input valid, kind, pos_x, pos_y, vel_x, vel_y, heading, yaw_rate,
		output ready);
endinterface

interface rft_result_if;
	logic               valid;
	logic               ready;
	logic               is_vehicle;
	logic signed [31:0] local_x;
	logic signed [31:0] local_y;
	logic signed [31:0] local_vx;
	logic signed [31:0] local_vy;
	logic signed [15:0] local_heading;

	modport source(output valid, is_vehicle, local_x, local_y, local_vx, local_vy,
		local_heading, input ready);
	modport sink(input valid, is_vehicle, local_x, local_y, local_vx, local_vy,
		local_heading, output ready);
endinterface

interface rft_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rft_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/rigid_frame_transform_with_rotation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_frame_transform_with_rotation_top
// Ego/obstacle/vehicle frame transform into the work-area local frame, on one
// shared multiply-accumulate unit under a sequencer.
// ----------------------------------------------------------------------------
// channel     dir   word
// item_in     in    kind, pos_x, pos_y, vel_x, vel_y, heading, yaw_rate
// result_out  out   is_vehicle, local_x, local_y, local_vx, local_vy, local_heading
// cfg         in    index, data (origin_x, origin_y)
//
// Ego word: stored, no result. Obstacle and vehicle words: their products go one
// at a time through the MAC; a vehicle word skips the global-frame steps.
// item_in.ready is high only while the sequencer is idle.
// A finished word waits in the output register; the next word runs meanwhile
// and holds in its last step until that register is free.
// Reset clears ego pose to zero and loads the origin reset values.
// ----------------------------------------------------------------------------
module rigid_frame_transform_with_rotation_top #(
	parameter int SINE_TABLE_DEPTH = rft_pkg::DEF_SINE_TABLE_DEPTH,
	parameter int SINE_WIDTH       = rft_pkg::DEF_SINE_WIDTH
) (
	input  wire          clk,
	input  wire          arst_n,
	rft_item_if.sink     item_in,
	rft_result_if.source result_out,
	rft_cfg_if.sink      cfg
);
	import rft_pkg::*;

	localparam int FRAC  = SINE_WIDTH - 2;
	localparam int TAB_W = SINE_WIDTH - 1;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int N_W   = $clog2(QUARTER_TURN * (SINE_TABLE_DEPTH + 1));
	localparam int M_W   = N_W - 8;
	localparam int Q_W   = M_W + RECIP_W;

	// sine quarter-wave table
	logic [TAB_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
			assign sine_rom[gi] = TAB_W'(sine_entry(gi, SINE_TABLE_DEPTH, FRAC));
		end
	endgenerate

	rft_state_t state_q, state_d;
	mac_ctl_t   ctl;

	logic signed [31:0] origin_x_q, origin_y_q;
	logic signed [31:0] ego_px_q, ego_py_q, ego_vx_q, ego_vy_q;
	logic signed [15:0] ego_yaw_q;
	logic signed [23:0] ego_rate_q;

	logic               veh_q;
	logic signed [15:0] ang_q;
	logic [1:0]         quad_q;
	logic [M_W-1:0]     m_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [COEF_W-1:0] s_q, c_q;
	logic signed [23:0] w_q;
	logic signed [31:0] px_q, py_q, vx_q, vy_q;
	logic signed [31:0] gx_q, gy_q, gvx_q, gvy_q;
	logic signed [31:0] dx_q, dy_q;
	logic signed [DATA_W-1:0] p1_q, p2_q, lyu_q, u_q;
	logic signed [RES_W-1:0]  t_q;
	logic signed [31:0] lx_q, ly_q, lvx_q, lvy_q;
	logic signed [15:0] head_q;
	logic signed [ACC_W-1:0] acc_q;

	logic               out_valid_q;
	logic               out_veh_q;
	logic signed [31:0] out_x_q, out_y_q, out_vx_q, out_vy_q;
	logic signed [15:0] out_head_q;

	logic in_acc;
	logic out_free;

	assign item_in.ready = (state_q == ST_IDLE);
	assign in_acc        = item_in.valid && item_in.ready;
	assign out_free      = !out_valid_q || result_out.ready;
	assign cfg.ready     = 1'b1;

	// angle reduction: quadrant and remainder
	logic signed [16:0] ang_pos;
	logic [15:0]        ang_r;
	logic [1:0]         quad;
	logic [13:0]        rem;
	logic [N_W-1:0]     n_val;
	logic [Q_W-1:0]     q_prod;

	always_comb begin
		ang_pos = 17'(ang_q);
		if (ang_pos < 0)
			ang_pos = ang_pos + 17'(FULL_TURN);
		ang_r = ang_pos[15:0];
		if (ang_r >= 16'(3 * QUARTER_TURN)) begin
			quad = 2'd3;
			rem  = 14'(ang_r - 16'(3 * QUARTER_TURN));
		end else if (ang_r >= 16'(HALF_TURN)) begin
			quad = 2'd2;
			rem  = 14'(ang_r - 16'(HALF_TURN));
		end else if (ang_r >= 16'(QUARTER_TURN)) begin
			quad = 2'd1;
			rem  = 14'(ang_r - 16'(QUARTER_TURN));
		end else begin
			quad = 2'd0;
			rem  = ang_r[13:0];
		end
		n_val  = N_W'(rem) * N_W'(SINE_TABLE_DEPTH) + N_W'(QUARTER_TURN / 2);
		q_prod = Q_W'(m_q) * Q_W'(RECIP);
	end

	// table read, one address a cycle
	logic [1:0]        rom_quad;
	logic [IDX_W-1:0]  rom_addr;
	logic [TAB_W-1:0]  rom_data;
	logic signed [COEF_W-1:0] rom_coef;

	always_comb begin
		rom_quad = (state_q == ST_COS) ? quad_q + 2'd1 : quad_q;
		rom_addr = rom_quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - idx_q : idx_q;
		rom_data = sine_rom[rom_addr];
		rom_coef = rom_quad[1] ? -COEF_W'(rom_data) : COEF_W'(rom_data);
	end

	// shared MAC
	logic signed [DATA_W-1:0] a_op;
	logic signed [COEF_W-1:0] b_op;
	logic signed [ACC_W-1:0]  prod, acc_sum, rnd;
	logic signed [RES_W-1:0]  r;

	always_comb begin
		case (ctl.a_sel)
			A_PX:    a_op = DATA_W'(px_q);
			A_PY:    a_op = DATA_W'(py_q);
			A_VX:    a_op = DATA_W'(vx_q);
			A_VY:    a_op = DATA_W'(vy_q);
			A_P1:    a_op = p1_q;
			A_P2:    a_op = p2_q;
			A_DX:    a_op = DATA_W'(dx_q);
			A_DY:    a_op = DATA_W'(dy_q);
			A_GVX:   a_op = DATA_W'(gvx_q);
			A_GVY:   a_op = DATA_W'(gvy_q);
			A_LYU:   a_op = lyu_q;
			A_U:     a_op = u_q;
			default: a_op = '0;
		endcase
		case (ctl.b_sel)
			B_S:     b_op = s_q;
			B_C:     b_op = c_q;
			B_NS:    b_op = -s_q;
			B_NC:    b_op = -c_q;
			B_W:     b_op = COEF_W'(w_q);
			default: b_op = '0;
		endcase
		prod    = ACC_W'(a_op) * ACC_W'(b_op);
		acc_sum = (ctl.first ? ACC_W'(0) : acc_q) + prod;
		if (ctl.shift16)
			rnd = (acc_sum + (ACC_W'(1) <<< 15)) >>> 16;
		else
			rnd = (acc_sum + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
		r = rnd[RES_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc && (item_in.kind == KIND_OBST || item_in.kind == KIND_VEH))
				state_d = ST_ANGLE;
			ST_ANGLE: state_d = ST_INDEX;
			ST_INDEX: state_d = ST_SIN;
			ST_SIN:   state_d = ST_COS;
			ST_COS:   state_d = veh_q ? ST_DIFF : ST_G01;
			ST_G01:   state_d = ST_G02;
			ST_G02:   state_d = ST_G03;
			ST_G03:   state_d = ST_G04;
			ST_G04:   state_d = ST_G05;
			ST_G05:   state_d = ST_G06;
			ST_G06:   state_d = ST_G07;
			ST_G07:   state_d = ST_G08;
			ST_G08:   state_d = ST_G09;
			ST_G09:   state_d = ST_G10;
			ST_G10:   state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_L01;
			ST_L01:   state_d = ST_L02;
			ST_L02:   state_d = ST_L03;
			ST_L03:   state_d = ST_L04;
			ST_L04:   state_d = ST_L05;
			ST_L05:   state_d = ST_L06;
			ST_L06:   state_d = ST_L07;
			ST_L07:   state_d = ST_L08;
			ST_L08:   state_d = ST_L09;
			ST_L09:   state_d = ST_L10;
			ST_L10:   state_d = ST_L11;
			ST_L11:   state_d = ST_L12;
			ST_L12:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// MAC microcode
	always_comb begin
		ctl = '{a_sel: A_PX, b_sel: B_S, first: 1'b1, shift16: 1'b0, dst: D_NONE};
		case (state_q)
			ST_G01: ctl = '{A_PX,  B_S,  1'b1, 1'b0, D_NONE};
			ST_G02: ctl = '{A_PY,  B_C,  1'b0, 1'b0, D_P1};
			ST_G03: ctl = '{A_PX,  B_C,  1'b1, 1'b0, D_NONE};
			ST_G04: ctl = '{A_PY,  B_NS, 1'b0, 1'b0, D_P2};
			ST_G05: ctl = '{A_VX,  B_C,  1'b1, 1'b0, D_NONE};
			ST_G06: ctl = '{A_VY,  B_NS, 1'b0, 1'b0, D_T};
			ST_G07: ctl = '{A_P1,  B_W,  1'b1, 1'b1, D_GVX};
			ST_G08: ctl = '{A_VX,  B_S,  1'b1, 1'b0, D_NONE};
			ST_G09: ctl = '{A_VY,  B_C,  1'b0, 1'b0, D_T};
			ST_G10: ctl = '{A_P2,  B_W,  1'b1, 1'b1, D_GVY};
			ST_L01: ctl = '{A_DX,  B_C,  1'b1, 1'b0, D_NONE};
			ST_L02: ctl = '{A_DY,  B_S,  1'b0, 1'b0, D_LX};
			ST_L03: ctl = '{A_DX,  B_NS, 1'b1, 1'b0, D_NONE};
			ST_L04: ctl = '{A_DY,  B_C,  1'b0, 1'b0, D_LY};
			ST_L05: ctl = '{A_LYU, B_W,  1'b1, 1'b1, D_T};
			ST_L06: ctl = '{A_GVX, B_C,  1'b1, 1'b0, D_NONE};
			ST_L07: ctl = '{A_GVY, B_S,  1'b0, 1'b0, D_LVX};
			ST_L08: ctl = '{A_DX,  B_NC, 1'b1, 1'b0, D_NONE};
			ST_L09: ctl = '{A_DY,  B_NS, 1'b0, 1'b0, D_U};
			ST_L10: ctl = '{A_U,   B_W,  1'b1, 1'b1, D_T};
			ST_L11: ctl = '{A_GVX, B_NS, 1'b1, 1'b0, D_NONE};
			ST_L12: ctl = '{A_GVY, B_C,  1'b0, 1'b0, D_LVY};
			default: ;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			origin_x_q  <= 32'(ORIGIN_X_RESET);
			origin_y_q  <= 32'(ORIGIN_Y_RESET);
			ego_px_q    <= '0;
			ego_py_q    <= '0;
			ego_vx_q    <= '0;
			ego_vy_q    <= '0;
			ego_yaw_q   <= '0;
			ego_rate_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg.index)
					REG_ORIGIN_X: origin_x_q <= cfg.data;
					REG_ORIGIN_Y: origin_y_q <= cfg.data;
					default: ;
				endcase
			end
			if (in_acc && item_in.kind == KIND_EGO) begin
				ego_px_q   <= item_in.pos_x;
				ego_py_q   <= item_in.pos_y;
				ego_vx_q   <= item_in.vel_x;
				ego_vy_q   <= item_in.vel_y;
				ego_yaw_q  <= item_in.heading;
				ego_rate_q <= item_in.yaw_rate;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		acc_q <= acc_sum;
		case (state_q)
			ST_IDLE: begin
				px_q  <= item_in.pos_x;
				py_q  <= item_in.pos_y;
				vx_q  <= item_in.vel_x;
				vy_q  <= item_in.vel_y;
				gx_q  <= item_in.pos_x;
				gy_q  <= item_in.pos_y;
				gvx_q <= item_in.vel_x;
				gvy_q <= item_in.vel_y;
				veh_q <= (item_in.kind == KIND_VEH);
				if (item_in.kind == KIND_VEH) begin
					ang_q  <= item_in.heading;
					w_q    <= item_in.yaw_rate;
					head_q <= wrap_angle(18'(item_in.heading));
				end else begin
					ang_q  <= ego_yaw_q;
					w_q    <= ego_rate_q;
					head_q <= wrap_angle(18'(ego_yaw_q) + 18'(item_in.heading));
				end
			end
			ST_ANGLE: begin
				quad_q <= quad;
				m_q    <= n_val[N_W-1:8];
			end
			ST_INDEX: idx_q <= IDX_W'(q_prod >> RECIP_SH);
			ST_SIN:   s_q <= rom_coef;
			ST_COS:   c_q <= rom_coef;
			ST_DIFF: begin
				dx_q <= sat32(SUM_W'(gx_q) - SUM_W'(origin_x_q));
				dy_q <= sat32(SUM_W'(gy_q) - SUM_W'(origin_y_q));
				if (!veh_q)
					head_q <= wrap_angle(18'(head_q) - 18'(ego_yaw_q));
			end
			ST_DONE: begin
				if (out_free) begin
					out_veh_q  <= veh_q;
					out_x_q    <= lx_q;
					out_y_q    <= ly_q;
					out_vx_q   <= lvx_q;
					out_vy_q   <= lvy_q;
					out_head_q <= head_q;
				end
			end
			default: ;
		endcase
		case (ctl.dst)
			D_P1: p1_q <= r[DATA_W-1:0];
			D_P2: begin
				p2_q <= r[DATA_W-1:0];
				gx_q <= sat32(SUM_W'(ego_px_q) + SUM_W'(r));
				gy_q <= sat32(SUM_W'(ego_py_q) + SUM_W'(p1_q));
			end
			D_T:   t_q <= r;
			D_GVX: gvx_q <= sat32(SUM_W'(ego_vx_q) + SUM_W'(t_q) - SUM_W'(r));
			D_GVY: gvy_q <= sat32(SUM_W'(ego_vy_q) + SUM_W'(t_q) + SUM_W'(r));
			D_LX:  lx_q <= sat32(SUM_W'(r));
			D_LY: begin
				ly_q  <= sat32(SUM_W'(r));
				lyu_q <= r[DATA_W-1:0];
			end
			D_LVX: lvx_q <= sat32(SUM_W'(t_q) + SUM_W'(r));
			D_U:   u_q <= r[DATA_W-1:0];
			D_LVY: lvy_q <= sat32(SUM_W'(t_q) + SUM_W'(r));
			default: ;
		endcase
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.is_vehicle    = out_veh_q;
	assign result_out.local_x       = out_x_q;
	assign result_out.local_y       = out_y_q;
	assign result_out.local_vx      = out_vx_q;
	assign result_out.local_vy      = out_vy_q;
	assign result_out.local_heading = out_head_q;

endmodule
`default_nettype wire

>>> test/rigid_frame_transform_with_rotation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_frame_transform_with_rotation_top_tb
// Drives ego, obstacle and vehicle words into the frame transform, predicts
// every local-frame result in fixed point and checks each one in order, over
// several origin settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module rigid_frame_transform_with_rotation_top_tb;
	import rft_pkg::*;

	localparam int FRAC = DEF_SINE_WIDTH - 2;
	localparam int DEPTH = DEF_SINE_TABLE_DEPTH;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int RANDOM_ITEMS = 650;
	localparam int SETTLE = 60;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] px, py, vx, vy;
		logic signed [15:0] hd;
		logic signed [23:0] w;
	} word_in_t;

	typedef struct {
		logic               is_vehicle;
		logic signed [31:0] lx, ly, lvx, lvy;
		logic signed [15:0] hd;
	} word_out_t;

	class frame_scoreboard;
		longint    sine_tab[DEPTH+1];
		longint    org_x, org_y;
		longint    ego_px, ego_py, ego_vx, ego_vy, ego_yaw, ego_w;
		word_out_t due[$];
		int        errors;

		function new();
			longint unsigned x, x2, term;
			longint sum, v;
			for (int i = 0; i <= DEPTH; i++) begin
				x = (HALF_PI_Q30 * longint'(i) + DEPTH / 2) / DEPTH;
				x2 = (x * x) >> 30;
				term = x;
				sum = longint'(x);
				for (int n = 1; n <= 14; n++) begin
					term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) sum -= longint'(term);
					else sum += longint'(term);
				end
				v = (sum + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
				if (v < 0) v = 0;
				if (v > (64'sd1 <<< FRAC)) v = 64'sd1 <<< FRAC;
				sine_tab[i] = v;
			end
			org_x = ORIGIN_X_RESET;
			org_y = ORIGIN_Y_RESET;
			ego_px = 0; ego_py = 0; ego_vx = 0; ego_vy = 0; ego_yaw = 0; ego_w = 0;
			errors = 0;
		endfunction

		function longint rnd_shift(longint x, int n);
			return (x + (64'sd1 <<< (n - 1))) >>> n;
		endfunction

		function longint clip32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint wrap(longint a);
			longint r;
			r = (a + HALF_TURN) % FULL_TURN;
			if (r < 0) r += FULL_TURN;
			return r - HALF_TURN;
		endfunction

		function longint sine_of(longint a);
			longint r, quad, idx;
			r = a % FULL_TURN;
			if (r < 0) r += FULL_TURN;
			quad = r / QUARTER_TURN;
			idx = ((r % QUARTER_TURN) * DEPTH + QUARTER_TURN / 2) / QUARTER_TURN;
			if (quad % 2 == 1) idx = DEPTH - idx;
			return (quad >= 2) ? -sine_tab[idx] : sine_tab[idx];
		endfunction

		function longint rot(longint a, longint b, longint ka, longint kb);
			return rnd_shift(a * ka + b * kb, FRAC);
		endfunction

		function longint spin(longint w, longint p);
			return rnd_shift(w * p, 16);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == REG_ORIGIN_X) org_x = longint'($signed(data));
			else if (idx == REG_ORIGIN_Y) org_y = longint'($signed(data));
		endfunction

		function word_out_t to_local(longint gx, longint gy, longint gvx, longint gvy,
				longint c, longint s, longint w);
			word_out_t r;
			longint dx, dy, ly;
			dx = clip32(gx - org_x);
			dy = clip32(gy - org_y);
			ly = rot(dx, dy, -s, c);
			r.lx  = clip32(rot(dx, dy, c, s));
			r.ly  = clip32(ly);
			r.lvx = clip32(spin(w, ly) + rot(gvx, gvy, c, s));
			r.lvy = clip32(spin(w, rot(dx, dy, -c, -s)) + rot(gvx, gvy, -s, c));
			return r;
		endfunction

		function void note_item(word_in_t it);
			word_out_t r;
			longint c, s, p1, p2, hd;
			hd = it.hd;
			if (it.kind == KIND_EGO) begin
				ego_px = it.px; ego_py = it.py; ego_vx = it.vx; ego_vy = it.vy;
				ego_yaw = hd; ego_w = it.w;
			end else if (it.kind == KIND_OBST) begin
				c = sine_of(ego_yaw + QUARTER_TURN);
				s = sine_of(ego_yaw);
				p1 = rot(it.px, it.py, s, c);
				p2 = rot(it.px, it.py, c, -s);
				r = to_local(clip32(ego_px + p2), clip32(ego_py + p1),
					clip32(ego_vx + rot(it.vx, it.vy, c, -s) - spin(ego_w, p1)),
					clip32(ego_vy + rot(it.vx, it.vy, s, c) + spin(ego_w, p2)),
					c, s, ego_w);
				r.is_vehicle = 1'b0;
				r.hd = 16'(wrap(wrap(ego_yaw + hd) - ego_yaw));
				due = {due, r};
			end else if (it.kind == KIND_VEH) begin
				c = sine_of(hd + QUARTER_TURN);
				s = sine_of(hd);
				r = to_local(it.px, it.py, it.vx, it.vy, c, s, it.w);
				r.is_vehicle = 1'b1;
				r.hd = 16'(wrap(hd));
				due = {due, r};
			end
		endfunction

		function void check_result(word_out_t got);
			word_out_t e;
			if (due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = due.pop_front();
			if (got.is_vehicle !== e.is_vehicle) begin
				$error("is_vehicle expected %0d got %0d", e.is_vehicle, got.is_vehicle);
				errors++;
			end
			if (got.lx !== e.lx) begin
				$error("local_x expected %0d got %0d", e.lx, got.lx);
				errors++;
			end
			if (got.ly !== e.ly) begin
				$error("local_y expected %0d got %0d", e.ly, got.ly);
				errors++;
			end
			if (got.lvx !== e.lvx) begin
				$error("local_vx expected %0d got %0d", e.lvx, got.lvx);
				errors++;
			end
			if (got.lvy !== e.lvy) begin
				$error("local_vy expected %0d got %0d", e.lvy, got.lvy);
				errors++;
			end
			if (got.hd !== e.hd) begin
				$error("local_heading expected %0d got %0d", e.hd, got.hd);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	frame_scoreboard sb = new();

	rft_item_if   item_in();
	rft_result_if result_out();
	rft_cfg_if    cfg();

	rigid_frame_transform_with_rotation_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_in(item_in.sink), .result_out(result_out.source), .cfg(cfg.sink)
	);

	always #10 clk = ~clk;

	initial begin
		item_in.valid = 1'b0;
		item_in.kind = KIND_EGO;
		item_in.pos_x = '0; item_in.pos_y = '0;
		item_in.vel_x = '0; item_in.vel_y = '0;
		item_in.heading = '0; item_in.yaw_rate = '0;
		result_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_ORIGIN_X;
		cfg.data = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk)
		result_out.ready <= arst_n && ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		word_out_t got;
		if (arst_n && result_out.valid && result_out.ready) begin
			got.is_vehicle = result_out.is_vehicle;
			got.lx = result_out.local_x;
			got.ly = result_out.local_y;
			got.lvx = result_out.local_vx;
			got.lvy = result_out.local_vy;
			got.hd = result_out.local_heading;
			sb.check_result(got);
		end
	end

	task automatic send_word(word_in_t it);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			item_in.valid <= 1'b0;
		end
		@(negedge clk);
		item_in.valid <= 1'b1;
		item_in.kind <= it.kind;
		item_in.pos_x <= it.px; item_in.pos_y <= it.py;
		item_in.vel_x <= it.vx; item_in.vel_y <= it.vy;
		item_in.heading <= it.hd; item_in.yaw_rate <= it.w;
		do @(posedge clk); while (!item_in.ready);
		sb.note_item(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// drop valid, drain all expected words, then let the sequencer settle
	task automatic drain();
		@(negedge clk);
		item_in.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic word_in_t mk(logic [1:0] k, int px, int py, int vx, int vy,
			int hd, int w);
		word_in_t it;
		it.kind = k; it.px = px; it.py = py; it.vx = vx; it.vy = vy;
		it.hd = 16'(hd); it.w = 24'(w);
		return it;
	endfunction

	function automatic logic [31:0] rand_val();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 45) return 32'($urandom_range(0, 32'h03ff_ffff)) - 32'h0200_0000;
		if (sel < 70) return 32'($urandom_range(0, 32'h3fff_ffff)) - 32'h2000_0000;
		if (sel < 92) return $urandom;
		if (sel < 96) return 32'h7fff_ffff;
		return 32'h8000_0000;
	endfunction

	function automatic word_in_t rand_word();
		word_in_t it;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 22) it.kind = KIND_EGO;
		else if (sel < 60) it.kind = KIND_OBST;
		else if (sel < 96) it.kind = KIND_VEH;
		else it.kind = KIND_SPARE;
		it.px = rand_val(); it.py = rand_val();
		it.vx = rand_val(); it.vy = rand_val();
		if ($urandom_range(99) < 85)
			it.hd = 16'(int'($urandom_range(0, FULL_TURN - 1)) - HALF_TURN);
		else
			it.hd = 16'($urandom);
		if ($urandom_range(99) < 75)
			it.w = 24'(int'($urandom_range(0, 24'h07ffff)) - 24'h040000);
		else
			it.w = 24'($urandom);
		return it;
	endfunction

	task automatic run_random(int count);
		word_in_t it;
		int sent;
		sent = 0;
		while (sent < count) begin
			it = rand_word();
			send_word(it);
			if (it.kind != KIND_SPARE) sent++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero pose, field extremes, angle corners, ignored kind
		send_word(mk(KIND_OBST, 0, 0, 0, 0, 0, 0));
		send_word(mk(KIND_VEH, 0, 0, 0, 0, 0, 0));
		send_word(mk(KIND_VEH, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			23039, 24'h7fffff));
		send_word(mk(KIND_VEH, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			-23040, 24'h800000));
		send_word(mk(KIND_VEH, 65536, -65536, 131072, 0, QUARTER_TURN, 65536));
		send_word(mk(KIND_VEH, 65536, 65536, 0, 131072, 16'h7fff, -65536));
		send_word(mk(KIND_VEH, -65536, 65536, 0, 0, 16'h8000, 0));
		send_word(mk(KIND_EGO, 1000 << 16, -300 << 16, 5 << 16, 2 << 16, 5760, 32768));
		send_word(mk(KIND_OBST, 10 << 16, 3 << 16, 1 << 16, -1 << 16, 5000, 0));
		send_word(mk(KIND_OBST, 0, 0, 0, 0, 23039, 0));
		send_word(mk(KIND_SPARE, 7, 7, 7, 7, 7, 7));
		send_word(mk(KIND_OBST, 0, 0, 0, 0, -23040, 0));
		send_word(mk(KIND_EGO, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			-23040, 24'h7fffff));
		send_word(mk(KIND_OBST, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			16'h7fff, 0));
		send_word(mk(KIND_EGO, -5 << 16, 7 << 16, 0, 0, 16'h8000, 24'h800000));
		send_word(mk(KIND_OBST, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 16'h8000, 0));
		send_word(mk(KIND_OBST, 100 << 16, -100 << 16, 3 << 16, 4 << 16, 11520, 0));
		send_word(mk(KIND_EGO, 0, 0, 0, 0, -QUARTER_TURN, -65536));
		send_word(mk(KIND_OBST, 50 << 16, 20 << 16, 0, 1 << 16, -11520, 0));
		drain();

		// phase 1: random origin, no idling
		write_reg(REG_ORIGIN_X, $urandom);
		write_reg(REG_ORIGIN_Y, $urandom);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		idle_pct = 0; stall_pct = 0;
		run_random(RANDOM_ITEMS / 4);
		drain();

		// phase 2: extreme origin, sender idling
		write_reg(REG_ORIGIN_X, 32'h7fffffff);
		write_reg(REG_ORIGIN_Y, 32'h80000000);
		idle_pct = 50; stall_pct = 0;
		run_random(RANDOM_ITEMS / 4);
		drain();

		// phase 3: opposite extremes, receiver stalling
		write_reg(REG_ORIGIN_X, 32'h80000000);
		write_reg(REG_ORIGIN_Y, 32'h7fffffff);
		idle_pct = 0; stall_pct = 50;
		run_random(RANDOM_ITEMS / 4);
		drain();

		// phase 4: zero origin, both sides idling
		write_reg(REG_ORIGIN_X, '0);
		write_reg(REG_ORIGIN_Y, '0);
		idle_pct = 28; stall_pct = 28;
		run_random(RANDOM_ITEMS / 4);
		drain();

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
